/* rtl/msp_pkg.sv */
// Package for the memory access piece splitter.
// Holds sizes, piece codes, the piece and step structs and the chunk length helper.
// No dependencies.
package msp_pkg;

	// Block geometry and limits
	localparam int BLOCK_BYTES      = 64;
	localparam int MAX_ACCESS_BYTES = 64;
	localparam int MAX_RESULTS      = 12;

	// Field widths
	localparam int TID_W  = 8;
	localparam int ADDR_W = 64;
	localparam int LEN_W  = 7;
	localparam int SIZE_W = 4;

	// Derived widths
	localparam int OFS_W  = $clog2(BLOCK_BYTES);
	localparam int ROOM_W = OFS_W + 1;
	localparam int SPAN_W = (LEN_W > ROOM_W) ? LEN_W : ROOM_W;
	localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [ROOM_W-1:0] room_t;
	typedef logic [SIZE_W-1:0] size_t_t;

	// Piece size codes
	localparam size_t_t SZ_8 = SIZE_W'(8);
	localparam size_t_t SZ_4 = SIZE_W'(4);
	localparam size_t_t SZ_2 = SIZE_W'(2);
	localparam size_t_t SZ_1 = SIZE_W'(1);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// One outgoing piece
	typedef struct packed {
		logic [TID_W-1:0]  thread;
		logic [ADDR_W-1:0] address;
		size_t_t           bytes;
		logic              last;
	} piece_t;

	// Result of one pass through the shared step unit
	typedef struct packed {
		size_t_t           size;
		logic [ADDR_W-1:0] next_addr;
		len_t              next_chunk;
		len_t              next_left;
		logic              done;
	} step_t;

	// Chunk length: smaller of the room left in the block and the bytes left
	function automatic len_t chunk_len(room_t room, len_t left);
		logic [SPAN_W-1:0] r;
		logic [SPAN_W-1:0] l;
		r = SPAN_W'(room);
		l = SPAN_W'(left);
		// the minimum never exceeds left, so it fits in LEN_W bits
		chunk_len = (r < l) ? LEN_W'(r) : left;
	endfunction

endpackage

/* rtl/msp_acc_if.sv */
// Access channel: one memory access per item.
// Depends on msp_pkg for field widths.
interface msp_acc_if;
	logic                         valid;
	logic                         ready;
	logic [msp_pkg::TID_W-1:0]    thread_id;
	logic [msp_pkg::ADDR_W-1:0]   start_address;
	logic [msp_pkg::LEN_W-1:0]    access_bytes;

	modport source (output valid, thread_id, start_address, access_bytes, input ready);
	modport sink   (input valid, thread_id, start_address, access_bytes, output ready);
endinterface

/* rtl/msp_piece_if.sv */
// Piece channel: one naturally sized piece per item.
// Depends on msp_pkg for field widths.
interface msp_piece_if;
	logic                         valid;
	logic                         ready;
	logic [msp_pkg::TID_W-1:0]    piece_thread;
	logic [msp_pkg::ADDR_W-1:0]   piece_address;
	logic [msp_pkg::SIZE_W-1:0]   piece_bytes;
	logic                         piece_last;

	modport source (output valid, piece_thread, piece_address, piece_bytes, piece_last,
		input ready);
	modport sink   (input valid, piece_thread, piece_address, piece_bytes, piece_last,
		output ready);
endinterface

/* rtl/msp_step.sv */
// Shared step unit: picks the next piece size, advances the address and
// refills the chunk at a block boundary. Depends on msp_pkg.
module msp_step (
	input  logic [msp_pkg::ADDR_W-1:0] addr,
	input  msp_pkg::len_t              chunk,
	input  msp_pkg::len_t              left,
	output msp_pkg::step_t             res
);
	import msp_pkg::*;

	size_t_t size;
	len_t    remain;
	len_t    refill;

	// Greedy size choice
	always_comb begin
		if (chunk >= LEN_W'(8)) begin
			size = SZ_8;
		end else if (chunk >= LEN_W'(4)) begin
			size = SZ_4;
		end else if (chunk >= LEN_W'(2)) begin
			size = SZ_2;
		end else begin
			size = SZ_1;
		end
	end

	assign remain = chunk - LEN_W'(size);
	assign refill = chunk_len(ROOM_W'(BLOCK_BYTES), left);

	// Address advance and chunk bookkeeping
	always_comb begin
		res.size      = size;
		res.next_addr = addr + ADDR_W'(size);
		if (remain == '0) begin
			res.next_chunk = refill;
			res.next_left  = left - refill;
			res.done       = (left == '0);
		end else begin
			res.next_chunk = remain;
			res.next_left  = left;
			res.done       = 1'b0;
		end
	end

endmodule

/* rtl/msp_seq.sv */
// Sequencer: takes one access, then drives the step unit once per piece.
// Depends on msp_pkg, msp_acc_if and msp_step.
module msp_seq (
	input  logic            clk,
	input  logic            arst_n,
	msp_acc_if.sink         acc,
	input  logic            take,
	output logic            piece_v,
	output msp_pkg::piece_t piece_d
);
	import msp_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic [TID_W-1:0]    tid_q;
	logic [ADDR_W-1:0]   addr_q;
	len_t                chunk_q;
	len_t                left_q;
	logic [CNT_W-1:0]    count_q;

	len_t                left0;
	room_t               room0;
	len_t                chunk0;
	logic                start;
	logic                emit;
	logic                last;
	step_t               step;

	msp_step u_step (
		.addr  (addr_q),
		.chunk (chunk_q),
		.left  (left_q),
		.res   (step)
	);

	// First chunk of the incoming access
	assign left0  = (acc.access_bytes > LEN_W'(MAX_ACCESS_BYTES)) ?
		LEN_W'(MAX_ACCESS_BYTES) : acc.access_bytes;
	assign room0  = ROOM_W'(BLOCK_BYTES) - ROOM_W'(acc.start_address[OFS_W-1:0]);
	assign chunk0 = chunk_len(room0, left0);

	assign last   = step.done || (count_q == CNT_W'(MAX_RESULTS - 1));

	// Next state and handshake
	always_comb begin
		state_d   = state_q;
		acc.ready = 1'b0;
		start     = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				acc.ready = 1'b1;
				if (acc.valid && left0 != '0) begin
					start   = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (take) begin
					emit = 1'b1;
					if (last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= '0;
		end else if (emit) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tid_q   <= acc.thread_id;
			addr_q  <= acc.start_address;
			chunk_q <= chunk0;
			left_q  <= left0 - chunk0;
		end else if (emit) begin
			addr_q  <= step.next_addr;
			chunk_q <= step.next_chunk;
			left_q  <= step.next_left;
		end
	end

	// Piece toward the output register
	assign piece_v         = emit;
	assign piece_d.thread  = tid_q;
	assign piece_d.address = addr_q;
	assign piece_d.bytes   = step.size;
	assign piece_d.last    = last;

	// Checks
	a_chunk_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> chunk_q != '0)
		else $error("empty chunk while running");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && last |=> state_q == ST_IDLE)
		else $error("sequencer kept running after last piece");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RESULTS))
		else $error("piece count past limit");

	a_no_take_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && !take |=> $stable(addr_q) && $stable(chunk_q))
		else $error("step advanced without a free output slot");

endmodule

/* rtl/memory_access_piece_splitter_top.sv */
// Memory access piece splitter, top level.
// Depends on msp_pkg, msp_acc_if, msp_piece_if and msp_seq.
//
// Usage:
//  - acc (valid/ready) carries one access: thread_id, start_address and
//    access_bytes (above 64 is treated as 64, zero gives no pieces).
//  - piece (valid/ready) carries one piece per item in ascending address
//    order: thread, address, size 8/4/2/1 and a last flag.
//  - The access is cut at every 64-byte block boundary, each chunk into
//    8-byte pieces followed by at most one 4-, 2- and 1-byte piece.
//  - One access occupies the block until its last piece is issued; acc.ready
//    is high only between accesses. The address step unit issues one piece a
//    cycle while the output register is free to take it.
//  - Each piece is registered in the sequencer, then in the output register.
//  - A stalled receiver holds the output register; the sequencer waits with
//    it and no piece is dropped.
//  - Reset (arst_n low, asynchronous) returns to idle and clears the output
//    valid; a partly split access is discarded.
module memory_access_piece_splitter_top (
	input  logic      clk,
	input  logic      arst_n,
	msp_acc_if.sink   acc,
	msp_piece_if.source piece
);
	import msp_pkg::*;

	logic   take;
	logic   piece_v;
	piece_t piece_d;
	logic   valid_q;
	piece_t out_q;

	msp_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.take    (take),
		.piece_v (piece_v),
		.piece_d (piece_d)
	);

	// Output register is free when empty or being drained
	assign take = !valid_q || piece.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= piece_v;
		end
	end

	always_ff @(posedge clk) begin
		if (take && piece_v) begin
			out_q <= piece_d;
		end
	end

	assign piece.valid         = valid_q;
	assign piece.piece_thread  = out_q.thread;
	assign piece.piece_address = out_q.address;
	assign piece.piece_bytes   = out_q.bytes;
	assign piece.piece_last    = out_q.last;

endmodule

/* bench/memory_access_piece_splitter_checker.sv */
// Checker for the memory access piece splitter: watches both channels and
// predicts the pieces of each taken access. Compares them in order.
// Depends on msp_pkg, msp_acc_if and msp_piece_if.
`timescale 1ns / 1ps
module memory_access_piece_splitter_checker (
	input  logic  clk,
	input  logic  arst_n,
	msp_acc_if    acc,
	msp_piece_if  piece,
	output int    errors,
	output int    pending
);
	import msp_pkg::*;

	// pieces still owed by the block, oldest first
	piece_t due_pieces[$];

	// Cut one access at block boundaries, then greedily into 8/4/2/1 pieces
	function automatic void cut_access(logic [TID_W-1:0] tid, logic [ADDR_W-1:0] addr,
		logic [LEN_W-1:0] len);
		piece_t cut[MAX_RESULTS];
		int left;
		int room;
		int seg;
		int count;
		size_t_t sz;
		left  = (int'(len) > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : int'(len);
		room  = BLOCK_BYTES - int'(addr % BLOCK_BYTES);
		count = 0;
		while (left > 0 && count < MAX_RESULTS) begin
			seg  = (room < left) ? room : left;
			left -= seg;
			while (seg > 0 && count < MAX_RESULTS) begin
				if (seg >= 8)
					sz = SZ_8;
				else if (seg >= 4)
					sz = SZ_4;
				else if (seg >= 2)
					sz = SZ_2;
				else
					sz = SZ_1;
				cut[count] = '{thread: tid, address: addr, bytes: sz, last: 1'b0};
				count++;
				addr += ADDR_W'(sz);
				seg  -= int'(sz);
			end
			room = BLOCK_BYTES;
		end
		if (count > 0)
			cut[count-1].last = 1'b1;
		for (int i = 0; i < count; i++)
			due_pieces.push_back(cut[i]);
	endfunction

	initial begin
		errors  = 0;
		pending = 0;
	end

	// Compare taken pieces first, then predict the newly taken access
	always @(posedge clk) begin
		piece_t want;
		if (arst_n) begin
			if (piece.valid && piece.ready) begin
				if (due_pieces.size() == 0) begin
					$error("piece with nothing expected: thread %0d address %h",
						piece.piece_thread, piece.piece_address);
					errors++;
				end else begin
					want = due_pieces.pop_front();
					if (piece.piece_thread !== want.thread) begin
						$error("piece_thread: expected %0d, got %0d", want.thread,
							piece.piece_thread);
						errors++;
					end
					if (piece.piece_address !== want.address) begin
						$error("piece_address: expected %h, got %h", want.address,
							piece.piece_address);
						errors++;
					end
					if (piece.piece_bytes !== want.bytes) begin
						$error("piece_bytes: expected %0d, got %0d", want.bytes,
							piece.piece_bytes);
						errors++;
					end
					if (piece.piece_last !== want.last) begin
						$error("piece_last: expected %0d, got %0d", want.last,
							piece.piece_last);
						errors++;
					end
				end
			end
			if (acc.valid && acc.ready)
				cut_access(acc.thread_id, acc.start_address, acc.access_bytes);
			pending = due_pieces.size();
		end
	end

endmodule

/* bench/memory_access_piece_splitter_top_test.sv */
// Top of the piece splitter bench: clock, reset, access stimulus, piece
// receiver with stalls, watchdog and verdict.
// Depends on msp_pkg, the channel interfaces, the block and its checker.
`timescale 1ns / 1ps
module memory_access_piece_splitter_top_test;
	import msp_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int LONG_HOLD    = 300;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   quiet_cycles;

	msp_acc_if   acc_ch();
	msp_piece_if piece_ch();

	memory_access_piece_splitter_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc_ch),
		.piece  (piece_ch)
	);

	memory_access_piece_splitter_checker checker_inst (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc_ch),
		.piece   (piece_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one access after an optional random gap; return once it is taken
	task automatic offer(input logic [TID_W-1:0] tid, input logic [ADDR_W-1:0] addr,
		input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < tx_idle_pct) begin
			acc_ch.valid <= 1'b0;
			@(posedge clk);
		end
		acc_ch.valid         <= 1'b1;
		acc_ch.thread_id     <= tid;
		acc_ch.start_address <= addr;
		acc_ch.access_bytes  <= len;
		do @(negedge clk); while (!acc_ch.ready);
		@(posedge clk);
	endtask

	// Hold the sender idle until every predicted piece has come out
	task automatic drain();
		acc_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Addresses: plain random, near the top of the space, 0 to 7 bytes past a block boundary
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [ADDR_W-1:0] a;
		a = {$urandom, $urandom};
		case ($urandom_range(3))
			0: a = 64'hFFFF_FFFF_FFFF_FF80 | ADDR_W'($urandom_range(127));
			1: a = (a & ~ADDR_W'(BLOCK_BYTES - 1)) | ADDR_W'($urandom_range(7));
			default: ;
		endcase
		return a;
	endfunction

	// Sizes: mostly legal, some zero, full and oversized
	function automatic logic [LEN_W-1:0] pick_bytes();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		else if (r < 18)
			return LEN_W'($urandom_range(127, MAX_ACCESS_BYTES + 1));
		else if (r < 30)
			return LEN_W'(MAX_ACCESS_BYTES);
		return LEN_W'($urandom_range(MAX_ACCESS_BYTES - 1, 1));
	endfunction

	task automatic random_phase(input int n, input int tx_pct, input int rx_pct,
		input int pause_at);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				drain();
			offer(TID_W'($urandom_range(255)), pick_address(), pick_bytes());
		end
	endtask

	// Receiver: random stalls, plus a long hold-off now and then
	initial begin : receiver
		int taken;
		int hold;
		int hold_at;
		taken   = 0;
		hold    = 0;
		hold_at = 150;
		piece_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (piece_ch.valid && piece_ch.ready)
				taken++;
			if (hold > 0) begin
				hold--;
				piece_ch.ready <= 1'b0;
			end else if (taken >= hold_at) begin
				hold    = LONG_HOLD;
				hold_at = taken + 1000;
				piece_ch.ready <= 1'b0;
			end else begin
				piece_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long
	always @(posedge clk) begin
		if ((acc_ch.valid && acc_ch.ready) || (piece_ch.valid && piece_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("memory_access_piece_splitter_top_test: done, errors");
			$finish;
		end
	end

	initial begin
		quiet_cycles         = 0;
		tx_idle_pct          = 7;
		rx_idle_pct          = 63;
		arst_n               = 1'b0;
		acc_ch.valid         <= 1'b0;
		acc_ch.thread_id     <= '0;
		acc_ch.start_address <= '0;
		acc_ch.access_bytes  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: size extremes, block straddles, wrap at the top of memory
		offer(8'h00, 64'h0, 7'd0);
		offer(8'hFF, 64'h0, 7'd1);
		offer(8'h5A, 64'h0, 7'd64);
		offer(8'hA5, 64'h1, 7'd63);
		offer(8'h01, 64'h3F, 7'd64);
		offer(8'h02, 64'h3F, 7'd2);
		offer(8'h03, 64'h7, 7'd15);
		offer(8'h04, 64'h21, 7'd3);
		offer(8'h05, 64'h2, 7'd4);
		offer(8'h06, 64'h9, 7'd7);
		offer(8'h07, 64'h38, 7'd8);
		offer(8'h08, 64'h1B, 7'd57);
		offer(8'h80, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
		offer(8'h81, 64'hFFFF_FFFF_FFFF_FFC5, 7'd64);
		offer(8'h82, 64'hFFFF_FFFF_FFFF_FFFE, 7'd3);
		offer(8'h83, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
		offer(8'h84, 64'h8000_0000_0000_0001, 7'd65);
		offer(8'hC3, 64'hAAAA_5555_AAAA_5555, 7'd127);
		offer(8'h3C, 64'h5555_AAAA_5555_AAAA, 7'd100);
		offer(8'h7E, 64'h0123_4567_89AB_CDEF, 7'd33);
		drain();

		// Random: three pacing mixes
		random_phase(150, 7, 63, -1);
		drain();
		random_phase(150, 63, 7, 75);
		drain();
		random_phase(150, 0, 0, -1);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("memory_access_piece_splitter_top_test: done, clean");
		else
			$display("memory_access_piece_splitter_top_test: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
rtl/msp_pkg.sv
rtl/msp_acc_if.sv
rtl/msp_piece_if.sv
rtl/msp_step.sv
rtl/msp_seq.sv
rtl/memory_access_piece_splitter_top.sv
bench/memory_access_piece_splitter_checker.sv
bench/memory_access_piece_splitter_top_test.sv
